// ===== rtl/bba_pkg.sv =====
// bba_pkg: word types, field widths and the size-to-order function of the buddy allocator
// no dependencies; imported by the allocator top level
package bba_pkg;

   localparam int SIZE_W    = 11;   // size_blocks and usable_blocks width
   localparam int IDX_W     = 10;   // block_index and granted_index width
   localparam int CORD_W    = 4;    // order of an 11-bit size, 0..11
   localparam int CSR_RESET = 1024; // usable_blocks after reset

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [SIZE_W-1:0] size_blocks;
      logic [IDX_W-1:0]  block_index;
   } bba_req_type;

   typedef struct packed {
      logic             success;
      logic [IDX_W-1:0] granted_index;
   } bba_rsp_type;

   // smallest order whose power of two covers n
   function automatic logic [CORD_W-1:0] ceil_order(input logic [SIZE_W-1:0] n);
      logic [CORD_W-1:0] o;
      o = CORD_W'(SIZE_W);
      for (int j = SIZE_W; j >= 0; j--) begin
         if (((SIZE_W+1)'(1) << j) >= {1'b0, n}) o = CORD_W'(j);
      end
      return o;
   endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// bba_ram: generic single-write, single-read ram with registered read data
// no dependencies; holds the next-index links of the free lists
module bba_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// buddy_block_allocator: buddy allocator top level, list heads, link ram and sequencer
// depends on bba_pkg (types, ceil_order) and bba_ram (next-index store)
// alloc scans the orders, then splits off halves; free checks each merge level, walking the
//    list entry by entry; bad requests go straight to finish; one word at a time, req_stall
//    high until finished; list entries and orders are stepped through the single link ram port
// reset (synchronous) and csr writes taken while idle rebuild the lists, one greedy piece at a time
module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int NUM_BLOCKS = 1024,
   parameter int NUM_ORDERS = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bba_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bba_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   // link width holds every index plus the nil marker NUM_BLOCKS
   localparam int AW  = $clog2(NUM_BLOCKS);
   localparam int LW  = $clog2(NUM_BLOCKS + 1);
   localparam int OW  = $clog2(NUM_ORDERS + 1);
   localparam int HW  = $clog2(NUM_ORDERS);
   localparam int PW  = ((NUM_ORDERS > LW) ? NUM_ORDERS : LW) + 1;
   localparam int XW  = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
   localparam int RST_USE = (NUM_BLOCKS < CSR_RESET) ? NUM_BLOCKS : CSR_RESET;
   localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);

   typedef enum logic [9:0] {
      ST_BUILD = 10'b0000000001,  // greedy split of the region
      ST_IDLE  = 10'b0000000010,
      ST_SCAN  = 10'b0000000100,  // alloc: look for a non-empty list
      ST_POP   = 10'b0000001000,  // alloc: head takes the popped link
      ST_SPLIT = 10'b0000010000,  // alloc: push upper halves
      ST_MCHK  = 10'b0000100000,  // free: may we merge one level up
      ST_WCMP  = 10'b0001000000,  // free: compare list entry with buddy
      ST_WNXT  = 10'b0010000000,  // free: step to next entry
      ST_WREM  = 10'b0100000000,  // free: unlink the buddy
      ST_FIN   = 10'b1000000000   // hand result to the output register
   } state_type;

   function automatic logic [PW-1:0] pow2(input logic [OW-1:0] o);
      return PW'(1) << o;
   endfunction

   // largest capped order whose power of two fits in n
   function automatic logic [OW-1:0] floor_order(input logic [LW-1:0] n);
      logic [OW-1:0] k;
      k = '0;
      for (int j = 0; j < NUM_ORDERS; j++) begin
         if ((PW'(1) << j) <= PW'(n)) k = OW'(j);
      end
      return k;
   endfunction

   state_type        state_ff, state_in;
   logic [LW-1:0]    usable_ff, usable_in;
   logic [LW-1:0]    rem_ff, rem_in;
   logic [LW-1:0]    base_ff, base_in;
   logic [LW-1:0]    heads_ff [NUM_ORDERS];
   logic [LW-1:0]    heads_in [NUM_ORDERS];
   logic [OW-1:0]    ord_ff, ord_in;       // target order (alloc) or current order (free)
   logic [OW-1:0]    lvl_ff, lvl_in;       // scan / split level
   logic [LW-1:0]    hblk_ff, hblk_in;     // popped block
   logic [LW-1:0]    blk_ff, blk_in;       // block being freed
   logic [LW-1:0]    bud_ff, bud_in;
   logic [LW-1:0]    cur_ff, cur_in;
   logic [LW-1:0]    prev_ff, prev_in;
   logic [LW-1:0]    steps_ff, steps_in;
   logic             res_ok_ff, res_ok_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bba_rsp_type      rsp_data_ff, rsp_data_in;

   // link ram port
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [LW-1:0]    ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [LW-1:0]    ram_rdata;

   // push onto a list, shared by build, split and free
   logic             push_en;
   logic [OW-1:0]    push_ord;
   logic [LW-1:0]    push_blk;

   logic [CORD_W-1:0] co;
   logic [PW-1:0]     co_pow;
   logic [XW-1:0]     blk_x;
   logic [OW-1:0]     kfl;
   logic [OW-1:0]     jm;

   bba_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_links (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // new word only when idle and no csr write in the same cycle
   assign req_stall = (state_ff != ST_IDLE) || csr_wr_en;

   always_comb begin
      state_in     = state_ff;
      usable_in    = usable_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      heads_in     = heads_ff;
      ord_in       = ord_ff;
      lvl_in       = lvl_ff;
      hblk_in      = hblk_ff;
      blk_in       = blk_ff;
      bud_in       = bud_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      res_ok_in    = res_ok_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = cur_ff[AW-1:0];
      push_en      = 1'b0;
      push_ord     = '0;
      push_blk     = '0;
      co           = ceil_order(req_data.size_blocks);
      co_pow       = pow2(OW'(co));
      blk_x        = XW'(req_data.block_index);
      kfl          = floor_order(rem_ff);
      jm           = lvl_ff - OW'(1);

      case (state_ff)
         ST_BUILD: begin
            if (rem_ff != '0) begin
               push_en  = 1'b1;
               push_ord = kfl;
               push_blk = base_ff;
               base_in  = base_ff + LW'(pow2(kfl));
               rem_in   = rem_ff - LW'(pow2(kfl));
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_wr_en) begin
               // out-of-range counts saturate
               usable_in = (XW'(csr_wr_data) > XW'(NUM_BLOCKS)) ? NIL : LW'(csr_wr_data);
               rem_in    = usable_in;
               base_in   = '0;
               for (int i = 0; i < NUM_ORDERS; i++) heads_in[i] = NIL;
               state_in  = ST_BUILD;
            end else if (req_valid) begin
               res_ok_in  = 1'b0;
               res_idx_in = '0;
               if (req_data.size_blocks == '0 || int'(co) >= NUM_ORDERS ||
                   co_pow > PW'(usable_ff)) begin
                  state_in = ST_FIN;
               end else if (req_data.req_type == REQ_ALLOC) begin
                  ord_in   = OW'(co);
                  lvl_in   = OW'(co);
                  state_in = ST_SCAN;
               end else if ((blk_x & (XW'(co_pow) - XW'(1))) != '0 ||
                            blk_x + XW'(co_pow) > XW'(usable_ff)) begin
                  // misaligned or past the region
                  state_in = ST_FIN;
               end else begin
                  blk_in   = LW'(req_data.block_index);
                  ord_in   = OW'(co);
                  state_in = ST_MCHK;
               end
            end
         end
         ST_SCAN: begin
            if (int'(lvl_ff) < NUM_ORDERS && pow2(lvl_ff) <= PW'(usable_ff)) begin
               if (heads_ff[lvl_ff[HW-1:0]] < NIL) begin
                  hblk_in   = heads_ff[lvl_ff[HW-1:0]];
                  ram_raddr = heads_ff[lvl_ff[HW-1:0]][AW-1:0];
                  state_in  = ST_POP;
               end else begin
                  lvl_in = lvl_ff + OW'(1);
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_POP: begin
            heads_in[lvl_ff[HW-1:0]] = ram_rdata;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (lvl_ff > ord_ff) begin
               push_en  = 1'b1;
               push_ord = jm;
               push_blk = hblk_ff + LW'(pow2(jm));
               lvl_in   = jm;
            end else begin
               res_ok_in  = 1'b1;
               res_idx_in = IDX_W'(hblk_ff);
               state_in   = ST_FIN;
            end
         end
         ST_MCHK: begin
            if (int'(ord_ff) + 1 < NUM_ORDERS &&
                pow2(ord_ff + OW'(1)) <= PW'(usable_ff)) begin
               bud_in   = blk_ff ^ LW'(pow2(ord_ff));
               cur_in   = heads_ff[ord_ff[HW-1:0]];
               prev_in  = NIL;
               steps_in = '0;
               state_in = ST_WCMP;
            end else begin
               push_en   = 1'b1;
               push_ord  = ord_ff;
               push_blk  = blk_ff;
               res_ok_in = 1'b1;
               state_in  = ST_FIN;
            end
         end
         ST_WCMP: begin
            if (cur_ff < NIL && steps_ff < NIL) begin
               state_in = (cur_ff == bud_ff) ? ST_WREM : ST_WNXT;
            end else begin
               // buddy not listed: stop merging here
               push_en   = 1'b1;
               push_ord  = ord_ff;
               push_blk  = blk_ff;
               res_ok_in = 1'b1;
               state_in  = ST_FIN;
            end
         end
         ST_WNXT: begin
            prev_in  = cur_ff;
            cur_in   = ram_rdata;
            steps_in = steps_ff + LW'(1);
            state_in = ST_WCMP;
         end
         ST_WREM: begin
            if (prev_ff >= NIL) begin
               heads_in[ord_ff[HW-1:0]] = ram_rdata;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = prev_ff[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (bud_ff < blk_ff) blk_in = bud_ff;
            ord_in   = ord_ff + OW'(1);
            state_in = ST_MCHK;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.success       = res_ok_ff;
               rsp_data_in.granted_index = res_idx_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // push: link takes old head, head takes the block
      if (push_en && push_blk < NIL && int'(push_ord) < NUM_ORDERS) begin
         ram_we                     = 1'b1;
         ram_waddr                  = push_blk[AW-1:0];
         ram_wdata                  = heads_ff[push_ord[HW-1:0]];
         heads_in[push_ord[HW-1:0]] = push_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD;
         usable_ff    <= LW'(RST_USE);
         rem_ff       <= LW'(RST_USE);
         base_ff      <= '0;
         for (int i = 0; i < NUM_ORDERS; i++) heads_ff[i] <= NIL;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         usable_ff    <= usable_in;
         rem_ff       <= rem_in;
         base_ff      <= base_in;
         heads_ff     <= heads_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      ord_ff      <= ord_in;
      lvl_ff      <= lvl_in;
      hblk_ff     <= hblk_in;
      blk_ff      <= blk_in;
      bud_ff      <= bud_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      res_ok_ff   <= res_ok_in;
      res_idx_ff  <= res_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_usable_range: assert property (@(posedge clock) disable iff (reset)
      usable_ff <= NIL) else $error("usable count above block count");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= NIL) else $error("list walk ran past its bound");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN)) else $error("result word outside finish");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE) else $error("accepted word not started");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the buddy block allocator (alloc, free, merge, csr rebuild)
// depends on bba_pkg and buddy_block_allocator; predicts every response word with its own
//    model of the per-order free lists and checks it against the dut in order
module tb_top
   import bba_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBLK  = 1024;
   localparam int NORD  = 11;
   localparam int NIL   = NBLK;
   localparam int LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bba_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bba_rsp_type       rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;

   buddy_block_allocator #(.NUM_BLOCKS(NBLK), .NUM_ORDERS(NORD)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: free list heads per order and the next-index links
   int          managed;
   int          heads [NORD];
   int          links [NBLK];
   bba_rsp_type pending_rsp [$];
   int          errors = 0;
   int          idle_cycles = 0;

   // idling controls, percent of cycles spent idle
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int recv_hold_len = 0;

   // live allocations, so that frees are mostly well formed
   int held_idx [$];
   int held_size [$];

   function automatic int log2_floor_capped(int n);
      int k = 0;
      while (k + 1 < NORD && (1 << (k + 1)) <= n) k++;
      return k;
   endfunction

   function automatic int log2_ceil(int n);
      int j = 0;
      while (j < 30 && (1 << j) < n) j++;
      return j;
   endfunction

   function automatic void push_free(int ord, int b);
      if (ord >= NORD || b >= NBLK) return;
      links[b] = heads[ord];
      heads[ord] = b;
   endfunction

   function automatic void rebuild_lists(int value);
      int rem, base, k;
      managed = (value > NBLK) ? NBLK : value;
      foreach (heads[i]) heads[i] = NIL;
      foreach (links[i]) links[i] = NIL;
      rem = managed;
      base = 0;
      while (rem > 0) begin
         k = log2_floor_capped(rem);
         push_free(k, base);
         base += 1 << k;
         rem -= 1 << k;
      end
   endfunction

   function automatic bit unlink_buddy(int ord, int bud);
      int prev, cur, steps;
      prev = NIL;
      cur = heads[ord];
      steps = 0;
      while (cur < NBLK && steps < NBLK) begin
         if (cur == bud) begin
            if (prev >= NBLK) heads[ord] = links[cur];
            else links[prev] = links[cur];
            return 1'b1;
         end
         prev = cur;
         cur = links[cur];
         steps++;
      end
      return 1'b0;
   endfunction

   // expected response for one request word, updating the list state
   function automatic bba_rsp_type allocate_or_free(bba_req_type rq);
      bba_rsp_type r;
      int ord, blk, h, j, bud;
      r = '0;
      if (rq.size_blocks == 0) return r;
      ord = log2_ceil(int'(rq.size_blocks));
      if (ord >= NORD || (1 << ord) > managed) return r;
      if (rq.req_type == REQ_ALLOC) begin
         for (int i = ord; i < NORD && (1 << i) <= managed; i++) begin
            h = heads[i];
            if (h < NBLK) begin
               heads[i] = links[h];
               j = i;
               while (j > ord) begin
                  j--;
                  push_free(j, h + (1 << j));
               end
               r.success = 1'b1;
               r.granted_index = IDX_W'(h);
               return r;
            end
         end
         return r;
      end
      blk = int'(rq.block_index);
      if ((blk & ((1 << ord) - 1)) != 0) return r;
      if (blk + (1 << ord) > managed) return r;
      // merge upward while the buddy sits in the same-order list
      while (ord + 1 < NORD && (1 << (ord + 1)) <= managed) begin
         bud = blk ^ (1 << ord);
         if (!unlink_buddy(ord, bud)) break;
         if (bud < blk) blk = bud;
         ord++;
      end
      push_free(ord, blk);
      r.success = 1'b1;
      return r;
   endfunction

   // send one request word after the last one, idling at random
   task automatic send_word(bit typ, int size, int idx);
      bba_req_type rq;
      bba_rsp_type exp_rsp;
      do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      rq.req_type = typ;
      rq.size_blocks = SIZE_W'(size);
      rq.block_index = IDX_W'(idx);
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      exp_rsp = allocate_or_free(rq);
      pending_rsp.push_back(exp_rsp);
      if (typ == REQ_ALLOC && exp_rsp.success) begin
         held_idx.push_back(int'(exp_rsp.granted_index));
         held_size.push_back(size);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_usable(int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= SIZE_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rebuild_lists(value & 11'h7ff);
      held_idx.delete();
      held_size.delete();
   endtask

   // free a random live allocation (well formed)
   task automatic free_held();
      int k;
      k = $urandom_range(held_idx.size() - 1);
      send_word(REQ_FREE, held_size[k], held_idx[k]);
      held_idx.delete(k);
      held_size.delete(k);
   endtask

   task automatic test_directed();
      send_word(REQ_ALLOC, 0, 0);          // zero size
      send_word(REQ_FREE, 0, 0);
      send_word(REQ_ALLOC, 2047, 1023);    // too large
      send_word(REQ_ALLOC, 1024, 0);       // whole region
      send_word(REQ_ALLOC, 1, 0);          // nothing left
      send_word(REQ_FREE, 1024, 0);        // free whole region
      send_word(REQ_ALLOC, 3, 0);          // rounded up, splits all the way down
      send_word(REQ_ALLOC, 1, 0);
      send_word(REQ_ALLOC, 5, 0);
      send_word(REQ_FREE, 4, 2);           // misaligned
      send_word(REQ_FREE, 4, 0);
      send_word(REQ_FREE, 1, 4);
      send_word(REQ_FREE, 8, 8);           // merges back up
      send_word(REQ_FREE, 512, 1023);      // misaligned, high bits set
      write_usable(1);
      send_word(REQ_ALLOC, 2, 0);
      send_word(REQ_ALLOC, 1, 0);
      send_word(REQ_FREE, 1, 0);
      send_word(REQ_FREE, 1, 1);           // runs past the region
      write_usable(0);                     // empty lists
      send_word(REQ_ALLOC, 1, 0);
      write_usable(2047);                  // saturates
      send_word(REQ_ALLOC, 1024, 0);
      write_usable(1000);
      send_word(REQ_ALLOC, 512, 0);
      send_word(REQ_ALLOC, 512, 0);
   endtask

   // mostly alloc/free pairs of live regions, some noise
   task automatic test_random(int count, int usable);
      int pick, sz;
      write_usable(usable);
      repeat (count) begin
         pick = $urandom_range(99);
         sz = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 40);
         if (pick < 45 || held_idx.size() == 0)
            send_word(REQ_ALLOC, sz, $urandom_range(1023));
         else if (pick < 90)
            free_held();
         else
            send_word(REQ_FREE, sz, $urandom_range(1023));
      end
   endtask

   // long receiver hold-off while the sender keeps offering words
   task automatic test_backpressure();
      write_usable(1024);
      recv_hold_len = 300;
      recv_hold = 1'b1;
      repeat (20) send_word(REQ_ALLOC, $urandom_range(1, 16), 0);
      // sender pause until everything is back
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) free_held();
   endtask

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (recv_hold) begin
         rsp_stall <= 1'b1;
         if (recv_hold_len == 0) recv_hold <= 1'b0;
         else recv_hold_len <= recv_hold_len - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // response checker and watchdog
   always @(posedge clock) begin
      bba_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         idle_cycles <= 0;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.success !== exp_rsp.success ||
                rsp_data.granted_index !== exp_rsp.granted_index) begin
               $display("%0t: expected success %0d index %0d, actual success %0d index %0d",
                        $time, exp_rsp.success, exp_rsp.granted_index,
                        rsp_data.success, rsp_data.granted_index);
               errors++;
            end
         end
      end else if (!(req_valid && !req_stall)) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= LIMIT) begin
            $display("buddy_block_allocator: mismatch");
            $finish;
         end
      end else
         idle_cycles <= 0;
   end

   initial begin
      rebuild_lists(CSR_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (40) @(posedge clock);
      test_directed();
      send_idle_pct = 31; recv_idle_pct = 61;
      test_random(450, 1024);
      send_idle_pct = 61; recv_idle_pct = 31;
      test_random(450, 700);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(450, 1024);
      test_backpressure();
      drain();
      if (errors == 0) $display("buddy_block_allocator: match");
      else $display("buddy_block_allocator: mismatch");
      $finish;
   end

endmodule
